FILE: design/bdeq_pkg.sv
`timescale 1ns / 1ps

package bdeq_pkg;

	// Operation codes carried on the operation field
	typedef logic [2:0] op_t;

	localparam op_t OP_QUERY      = 3'd0;
	localparam op_t OP_PUSH_BACK  = 3'd1;
	localparam op_t OP_PUSH_FRONT = 3'd2;
	localparam op_t OP_POP_FRONT  = 3'd3;
	localparam op_t OP_POP_BACK   = 3'd4;

	// Default sizing
	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

endpackage

FILE: design/bounded_double_ended_queue_core.sv
`timescale 1ns / 1ps

// Channel  | Signals                                         | Direction
// ---------+-------------------------------------------------+----------
// in       | in_valid, in_stall, operation, item_data        | into core
// out      | out_valid, out_stall, ok, front_data, back_data, | out of core
//          | entry_count, is_empty, is_full                  |
//
// One transaction per cycle sustained while the result side does not stall;
// a taken transaction passes the input register, then the result register.
// Head index, back index and entry count close a loop through their own
// registers, so each operation sees the state left by the one before it.
// The entry store has one write port and two registered read ports (front,
// back) with write bypass; it is not cleared at reset.
// arst_n clears the head index, the count and all valid flags, and sets the back index to the last slot.
// A stalled result holds the pipe; in_stall rises once the input register
// is occupied and cannot move on.

module bounded_double_ended_queue_core
	import bdeq_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  op_t                                   operation,
	input  logic [DATA_WIDTH-1:0]                 item_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  ok,
	output logic [DATA_WIDTH-1:0]                 front_data,
	output logic [DATA_WIDTH-1:0]                 back_data,
	output logic [$clog2(CAPACITY+1)-1:0]         entry_count,
	output logic                                  is_empty,
	output logic                                  is_full
);

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

	// Input register
	logic                  valid_s1;
	op_t                   op_s1;
	logic [DATA_WIDTH-1:0] data_s1;

	// Queue state
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	// Result register
	logic                  valid_s2;
	logic                  ok_s2;
	logic [DATA_WIDTH-1:0] front_s2;
	logic [DATA_WIDTH-1:0] back_s2;
	logic [CNT_W-1:0]      count_s2;
	logic                  empty_s2;
	logic                  full_s2;

	// Entry store
	logic [DATA_WIDTH-1:0] store [CAPACITY];

	// Next-state logic
	logic             advance;
	logic             full_c;
	logic             empty_c;
	logic             ok_c;
	logic             wr_en;
	logic [PTR_W-1:0] wr_addr;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] head_dec;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] tail_dec;
	logic [PTR_W-1:0] head_nxt;
	logic [PTR_W-1:0] tail_nxt;
	logic [CNT_W-1:0] count_nxt;

	// Handshake: the result register frees when it is empty or taken
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Ring index stepping, valid for any capacity
	assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
	assign tail_inc = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
	assign tail_dec = (tail_q == '0) ? LAST_SLOT : tail_q - 1'b1;

	assign full_c  = (count_q == FULL_CNT);
	assign empty_c = (count_q == '0);

	// Operation decode
	always_comb begin
		ok_c      = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = tail_inc;
		head_nxt  = head_q;
		tail_nxt  = tail_q;
		count_nxt = count_q;
		unique case (op_s1)
			OP_QUERY: begin
				ok_c = 1'b1;
			end
			OP_PUSH_BACK: begin
				if (!full_c) begin
					ok_c      = 1'b1;
					wr_en     = 1'b1;
					wr_addr   = tail_inc;
					tail_nxt  = tail_inc;
					count_nxt = count_q + 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				if (!full_c) begin
					ok_c      = 1'b1;
					wr_en     = 1'b1;
					wr_addr   = head_dec;
					head_nxt  = head_dec;
					count_nxt = count_q + 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (!empty_c) begin
					ok_c      = 1'b1;
					head_nxt  = head_inc;
					count_nxt = count_q - 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (!empty_c) begin
					ok_c      = 1'b1;
					tail_nxt  = tail_dec;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				// unknown code: failed no-op
				ok_c = 1'b0;
			end
		endcase
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1   <= operation;
			data_s1 <= item_data;
		end
	end

	// Queue state; back index starts one slot behind the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= LAST_SLOT;
			count_q <= '0;
		end else if (advance) begin
			head_q  <= head_nxt;
			tail_q  <= tail_nxt;
			count_q <= count_nxt;
		end
	end

	// Entry store: one write port, front and back reads with bypass
	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			store[wr_addr] <= data_s1;
		end
		if (advance) begin
			front_s2 <= (wr_en && wr_addr == head_nxt) ? data_s1 : store[head_nxt];
			back_s2  <= (wr_en && wr_addr == tail_nxt) ? data_s1 : store[tail_nxt];
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			ok_s2    <= ok_c;
			count_s2 <= count_nxt;
			empty_s2 <= (count_nxt == '0);
			full_s2  <= (count_nxt == FULL_CNT);
		end
	end

	// Outputs; data reads as zero when the queue is empty
	assign out_valid   = valid_s2;
	assign ok          = ok_s2;
	assign front_data  = empty_s2 ? '0 : front_s2;
	assign back_data   = empty_s2 ? '0 : back_s2;
	assign entry_count = count_s2;
	assign is_empty    = empty_s2;
	assign is_full     = full_s2;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above capacity");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_SLOT && tail_q <= LAST_SLOT)
		else $error("ring index out of range");

	a_fail_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !ok_c |=> count_q == $past(count_q) && head_q == $past(head_q)
			&& tail_q == $past(tail_q))
		else $error("failed operation changed the queue");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && wr_en |=> count_q == $past(count_q) + 1'b1)
		else $error("push did not add one entry");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked transaction");
`endif

endmodule

FILE: tb/sv/bdeq_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deque core, keeps its own copy of the ring
// store, head and fill level, and checks every result against the status
// predicted when the matching transaction was taken.
module bdeq_checker
	import bdeq_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  op_t                           operation,
	input  logic [DATA_WIDTH-1:0]         item_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          ok,
	input  logic [DATA_WIDTH-1:0]         front_data,
	input  logic [DATA_WIDTH-1:0]         back_data,
	input  logic [$clog2(CAPACITY+1)-1:0] entry_count,
	input  logic                          is_empty,
	input  logic                          is_full,
	output int                            fail_count,
	output int                            pending
);

	localparam int COUNT_W = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic                  ok;
		logic [DATA_WIDTH-1:0] front;
		logic [DATA_WIDTH-1:0] back;
		logic [COUNT_W-1:0]    count;
		logic                  empty;
		logic                  full;
	} deque_status_t;

	// Mirror of the deque contents
	logic [DATA_WIDTH-1:0] ring [CAPACITY];
	int                    head_slot;
	int                    fill_level;
	deque_status_t         status_q [$];

	// Apply one operation to the mirror and return the status it leaves
	function automatic deque_status_t apply_deque_op(op_t op, logic [DATA_WIDTH-1:0] word);
		deque_status_t s;
		s = '0;
		case (op)
			OP_QUERY: begin
				s.ok = 1'b1;
			end
			OP_PUSH_BACK: begin
				if (fill_level < CAPACITY) begin
					ring[(head_slot + fill_level) % CAPACITY] = word;
					fill_level++;
					s.ok = 1'b1;
				end
			end
			OP_PUSH_FRONT: begin
				if (fill_level < CAPACITY) begin
					head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
					ring[head_slot] = word;
					fill_level++;
					s.ok = 1'b1;
				end
			end
			OP_POP_FRONT: begin
				if (fill_level > 0) begin
					head_slot = (head_slot + 1) % CAPACITY;
					fill_level--;
					s.ok = 1'b1;
				end
			end
			OP_POP_BACK: begin
				if (fill_level > 0) begin
					fill_level--;
					s.ok = 1'b1;
				end
			end
			default: begin
				// unknown codes fail and change nothing
				s.ok = 1'b0;
			end
		endcase
		if (fill_level > 0) begin
			s.front = ring[head_slot];
			s.back  = ring[(head_slot + fill_level - 1) % CAPACITY];
		end
		s.count = COUNT_W'(fill_level);
		s.empty = (fill_level == 0);
		s.full  = (fill_level == CAPACITY);
		return s;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch: expected %0h, got %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// Results are matched before new transactions are queued
	always @(posedge clk or negedge arst_n) begin
		deque_status_t want;
		if (!arst_n) begin
			head_slot  = 0;
			fill_level = 0;
			fail_count = 0;
			status_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					$display("%0t ns: result with none expected: ok %0b front %0h back %0h count %0d",
						$time, ok, front_data, back_data, entry_count);
					fail_count++;
				end else begin
					want = status_q.pop_front();
					check_field("ok", want.ok, ok);
					check_field("front_data", want.front, front_data);
					check_field("back_data", want.back, back_data);
					check_field("entry_count", want.count, entry_count);
					check_field("is_empty", want.empty, is_empty);
					check_field("is_full", want.full, is_full);
				end
			end
			if (in_valid && !in_stall)
				status_q.push_back(apply_deque_op(operation, item_data));
		end
		pending = status_q.size();
	end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import bdeq_pkg::*;

	localparam int CAPACITY   = DEF_CAPACITY;
	localparam int DATA_WIDTH = DEF_DATA_WIDTH;
	localparam int COUNT_W    = $clog2(CAPACITY + 1);
	localparam int RANDOM_OPS = 750;
	localparam int PHASE_LEN  = 188;
	localparam int HOLD_LEN   = 60;

	// codes outside the defined set
	localparam op_t OP_FIRST_UNKNOWN = 3'd5;
	localparam op_t OP_LAST_UNKNOWN  = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	op_t                   operation;
	logic [DATA_WIDTH-1:0] item_data;
	logic                  out_valid;
	logic                  out_stall;
	logic                  ok;
	logic [DATA_WIDTH-1:0] front_data;
	logic [DATA_WIDTH-1:0] back_data;
	logic [COUNT_W-1:0]    entry_count;
	logic                  is_empty;
	logic                  is_full;
	int                    fail_count;
	int                    pending;

	int                    gap_pct;
	int                    stall_pct;
	bit                    hold_off_req;

	bounded_double_ended_queue_core #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.item_data   (item_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.front_data  (front_data),
		.back_data   (back_data),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.is_full     (is_full)
	);

	bdeq_checker #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.item_data   (item_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.front_data  (front_data),
		.back_data   (back_data),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit
	initial begin
		#5_000_000;
		$display("[bounded_double_ended_queue_core] ERROR");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		int k;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				for (k = 0; k < HOLD_LEN; k++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Present one transaction and hold it until taken
	task automatic offer_op(op_t op, logic [DATA_WIDTH-1:0] word);
		while ($urandom_range(0, 99) < gap_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		operation <= op;
		item_data <= word;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	function automatic op_t pick_op(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return OP_QUERY;
		if (r < 7)
			return op_t'($urandom_range(OP_FIRST_UNKNOWN, OP_LAST_UNKNOWN));
		if ($urandom_range(0, 99) < push_pct)
			return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
		return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return DATA_WIDTH'($urandom);
	endfunction

	// Stimulus and verdict
	initial begin
		int i;
		int push_pct;
		int sender_gaps [4];
		int recv_stalls [4];
		sender_gaps  = '{0, 80, 0, 24};
		recv_stalls  = '{0, 0, 80, 24};
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_QUERY;
		item_data    = '0;
		gap_pct      = 0;
		stall_pct    = 0;
		hold_off_req = 1'b0;
		push_pct     = 50;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty queue, bad codes, fill to full, overflow
		offer_op(OP_QUERY, pick_word());
		offer_op(OP_POP_FRONT, pick_word());
		offer_op(OP_POP_BACK, pick_word());
		offer_op(OP_LAST_UNKNOWN, pick_word());
		offer_op(OP_PUSH_BACK, '0);
		offer_op(OP_PUSH_FRONT, '1);
		for (i = 0; i < CAPACITY - 2; i++)
			offer_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK, DATA_WIDTH'($urandom));
		offer_op(OP_PUSH_BACK, pick_word());
		offer_op(OP_PUSH_FRONT, pick_word());
		offer_op(OP_FIRST_UNKNOWN, pick_word());
		offer_op(op_t'(OP_FIRST_UNKNOWN + 3'd1), pick_word());
		offer_op(OP_QUERY, pick_word());

		// Random: phases of sender gaps and result stalls, with push bias moving the fill level around
		for (i = 0; i < RANDOM_OPS; i++) begin
			if (i % PHASE_LEN == 0 && i / PHASE_LEN < 4) begin
				gap_pct   = sender_gaps[i / PHASE_LEN];
				stall_pct = recv_stalls[i / PHASE_LEN];
				if (i == 0)
					hold_off_req = 1'b1;
			end
			if (i % 32 == 0)
				case ($urandom_range(0, 2))
					0: push_pct = 85;
					1: push_pct = 15;
					default: push_pct = 50;
				endcase
			offer_op(pick_op(push_pct), pick_word());
		end
		@(negedge clk);
		in_valid  <= 1'b0;
		stall_pct = 0;

		// Drain
		while (pending != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("[bounded_double_ended_queue_core] OK");
		else
			$display("[bounded_double_ended_queue_core] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
design/bdeq_pkg.sv
design/bounded_double_ended_queue_core.sv
tb/sv/bdeq_checker.sv
tb/sv/tb.sv
